### hdl/hough_line_vote_smooth_peak_defines.svh
// Assertion macros for the block's RTL.
`ifndef HOUGH_LINE_VOTE_SMOOTH_PEAK_DEFINES_SVH
`define HOUGH_LINE_VOTE_SMOOTH_PEAK_DEFINES_SVH

// Check that a property holds at every clock edge outside reset.
`define HLVSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define HLVSP_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### hdl/hlvsp_pkg.sv
package hlvsp_pkg;

    localparam int ANGLE_BINS   = 256;
    localparam int R_BINS_DEF   = 256;
    localparam int MAX_PEAKS_DEF = 64;
    localparam int TRIG_FRAC_DEF = 14;
    localparam int RADW         = 11;

    localparam logic CFG_ANGLE_SPREAD     = 1'b0;
    localparam logic CFG_ACCEPT_THRESHOLD = 1'b1;

    localparam logic FUNC_VOTE   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef struct packed {
        logic              func;
        logic signed [7:0] edge_x;
        logic signed [7:0] edge_y;
        logic        [7:0] edge_angle;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  peak_radius;
        logic [7:0]  peak_angle;
        logic [15:0] peak_score;
        logic        found;
        logic        last;
    } out_beat_t;

    // Quarter-wave sine at the given fraction bits, rounded to nearest.
    function automatic int quarter_sin(int j, int frac);
        real arg;
        real v;
        arg = 3.14159265358979323846 * j / 128.0;
        v = $floor($sin(arg) * (2.0 ** frac) + 0.5);
        if (j == 0)
            return 0;
        else if (j == 64)
            return 1 << frac;
        else
            return int'(v);
    endfunction

    // Fold a 256-step angle onto the quarter table: {negate, index}.
    function automatic logic [7:0] fold_angle(logic [7:0] k);
        logic [7:0] r;
        if (k <= 8'd64)
            r = {1'b0, k[6:0]};
        else if (k < 8'd128)
            r = {1'b0, 7'(8'd128 - k)};
        else if (k <= 8'd192)
            r = {1'b1, 7'(k - 8'd128)};
        else
            r = {1'b1, 7'(9'd256 - {1'b0, k})};
        return r;
    endfunction

    // Neighbor directions for peak checks.
    function automatic logic signed [1:0] dir_dr(logic [1:0] d);
        logic signed [1:0] v;
        case (d)
            2'd0: v = 2'sd1;
            2'd1: v = 2'sd1;
            2'd2: v = 2'sd0;
            default: v = -2'sd1;
        endcase
        return v;
    endfunction

    function automatic logic dir_dt(logic [1:0] d);
        return (d != 2'd0);
    endfunction

endpackage

### hdl/hough_line_vote_smooth_peak.sv
// Hough line accumulator: vote edge points, then smooth, extract peaks, clear.
// Channels: in_valid/in_stall carries one in_beat_t; func selects a vote
// (one edge point) or a finish run. out_valid/out_stall carries out_beat_t
// results, only from finish runs. cfg_valid/cfg_ready writes angle_spread
// (index 0) or accept_threshold (index 1); cfg_ready is always high.
// Items are taken one at a time. A vote walks 2*spread+1 angles; each
// angle waits on the radius computation, then reads each voted bin and
// writes it back saturated on the single accumulator memory; a dropped
// bin is skipped. A finish run smooths the accumulator, searches peaks
// bin by bin (up to nine reads through one memory port), clears the
// accumulator, then emits the peak beats.
// Reset: a clearing pass over the whole accumulator zeroes it; in_stall
// stays high until it ends.
// Stall: the output register holds a beat until it is taken; emission waits
// meanwhile. The final beat of a run may wait while the next item is taken.
`include "hough_line_vote_smooth_peak_defines.svh"

module hough_line_vote_smooth_peak #(
    parameter int R_BINS         = hlvsp_pkg::R_BINS_DEF,
    parameter int MAX_PEAKS      = hlvsp_pkg::MAX_PEAKS_DEF,
    parameter int TRIG_FRAC_BITS = hlvsp_pkg::TRIG_FRAC_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  hlvsp_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output hlvsp_pkg::out_beat_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [13:0]          cfg_data
);

    localparam int RW    = $clog2(R_BINS);
    localparam int AW    = 8 + RW;
    localparam int DEPTH = hlvsp_pkg::ANGLE_BINS << RW;
    localparam int HALF  = R_BINS / 2;
    localparam int PCW   = $clog2(MAX_PEAKS + 1);
    localparam int PIW   = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int RADW  = hlvsp_pkg::RADW;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_VR0   = 4'd2;
    localparam logic [3:0] S_VR0W  = 4'd3;
    localparam logic [3:0] S_VR1   = 4'd4;
    localparam logic [3:0] S_VR1W  = 4'd5;
    localparam logic [3:0] S_VBIN  = 4'd6;
    localparam logic [3:0] S_VWR   = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SWR   = 4'd9;
    localparam logic [3:0] S_PRD   = 4'd10;
    localparam logic [3:0] S_EMRD  = 4'd11;
    localparam logic [3:0] S_EMLD  = 4'd12;

    // Storage: accumulator (two read ports, one write), row 0 copy, peak list.
    logic [15:0] acc_mem  [DEPTH];
    logic [15:0] copy_mem [R_BINS];
    logic [31:0] peak_mem [MAX_PEAKS];

    logic [3:0]  state_reg, state_next;
    logic [4:0]  spread_reg;
    logic [13:0] thr_reg;
    logic signed [7:0] x_reg, x_next, y_reg, y_next;
    logic [7:0]  t_reg, t_next;
    logic [5:0]  steps_reg, steps_next;
    logic signed [RADW-1:0] rprev_reg, rprev_next, rnext_reg, rnext_next;
    logic signed [RADW-1:0] cur_reg, cur_next, hi_reg, hi_next;
    logic [RW:0] col_reg, col_next;
    logic [3:0]  n_reg, n_next;
    logic [15:0] z_reg, z_next;
    logic [15:0] prev_a_reg, prev_a_next, prev_b_reg, prev_b_next;
    logic [PCW-1:0] peak_count_reg, peak_count_next;
    logic [PCW-1:0] idx_reg, idx_next;
    logic        emit_pend_reg, emit_pend_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic        out_valid_reg, out_valid_next;
    hlvsp_pkg::out_beat_t out_data_reg, out_data_next;

    logic [15:0] rd_a_reg, rd_b_reg, copy_rd_reg;
    logic [31:0] peak_rd_reg;

    logic [AW-1:0] rd_a_addr, wr_addr;
    logic [15:0]   wr_data;
    logic          wr_en;
    logic          copy_we;
    logic          peak_we;
    logic          out_load;

    logic          in_take;
    logic          out_take;
    logic          rad_start;
    logic [7:0]    rad_k;
    logic          rad_done;
    logic signed [RADW-1:0] rad_r;

    logic signed [RADW:0] bin_s;
    logic          bin_ok;
    logic [AW-1:0] vote_addr;
    logic [17:0]   box_sum;
    logic signed [18:0] box_v;
    logic [15:0]   box_q;
    logic [15:0]   b_val;
    logic [3:0]    m_idx;
    logic [1:0]    p_dir;
    logic          p_fwd;
    logic [RW:0]   p_col;
    logic [7:0]    p_row;
    logic          p_pass;

    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    hlvsp_radius #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_radius (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rad_start),
        .x      (x_reg),
        .y      (y_reg),
        .k      (rad_k),
        .done   (rad_done),
        .radius (rad_r)
    );

    assign rad_start = (state_reg == S_VR0) || (state_reg == S_VR1);
    assign rad_k     = (state_reg == S_VR0) ? t_reg : t_reg + 8'd1;

    // Vote bin: radius offset by half the bins; out-of-range bins are dropped.
    assign bin_s     = (RADW + 1)'(cur_reg) + (RADW + 1)'(HALF);
    assign bin_ok    = !bin_s[RADW] && (bin_s < (RADW + 1)'(R_BINS));
    assign vote_addr = {t_reg, bin_s[RW-1:0]};

    // 2x2 boxcar; the last row pairs with the saved unsmoothed row 0.
    assign b_val   = (t_reg == 8'hff) ? copy_rd_reg : rd_b_reg;
    assign box_sum = 18'(prev_a_reg) + 18'(prev_b_reg) + 18'(rd_a_reg) + 18'(b_val);
    assign box_v   = $signed({1'b0, box_sum}) - $signed({3'b000, thr_reg, 2'b00});
    assign box_q   = box_v[18] ? 16'h0000 :
                     (box_v > 19'sd65535) ? 16'hffff : box_v[15:0];

    // Peak neighbor address for read slot n: center first, then each
    // direction forward and backward.
    always_comb begin
        p_dir = m_idx[2:1];
        p_fwd = !m_idx[0];
        if (n_reg == 4'd0)
        begin
            p_col = col_reg;
            p_row = t_reg;
        end
        else if (p_fwd)
        begin
            p_col = col_reg + (RW + 1)'(hlvsp_pkg::dir_dr(p_dir));
            p_row = t_reg + 8'(hlvsp_pkg::dir_dt(p_dir));
        end
        else
        begin
            p_col = col_reg - (RW + 1)'(hlvsp_pkg::dir_dr(p_dir));
            p_row = t_reg - 8'(hlvsp_pkg::dir_dt(p_dir));
        end
    end

    // Check the neighbor read in the previous slot.
    assign m_idx  = n_reg - 4'd1;
    assign p_pass = m_idx[0] ? (z_reg > rd_a_reg) : (z_reg >= rd_a_reg);

    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        t_next          = t_reg;
        steps_next      = steps_reg;
        rprev_next      = rprev_reg;
        rnext_next      = rnext_reg;
        cur_next        = cur_reg;
        hi_next         = hi_reg;
        col_next        = col_reg;
        n_next          = n_reg;
        z_next          = z_reg;
        prev_a_next     = prev_a_reg;
        prev_b_next     = prev_b_reg;
        peak_count_next = peak_count_reg;
        idx_next        = idx_reg;
        emit_pend_next  = emit_pend_reg;
        clr_addr_next   = clr_addr_reg;
        out_data_next   = out_data_reg;
        out_load        = 1'b0;
        rd_a_addr       = {t_reg, col_reg[RW-1:0]};
        wr_addr         = vote_addr;
        wr_data         = rd_a_reg + 16'((rd_a_reg != 16'hffff));
        wr_en           = 1'b0;
        copy_we         = 1'b0;
        peak_we         = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_addr       = clr_addr_reg;
                wr_data       = 16'h0000;
                wr_en         = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == {AW{1'b1}})
                begin
                    idx_next       = '0;
                    emit_pend_next = 1'b0;
                    state_next     = emit_pend_reg ? S_EMRD : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (in_data.func == hlvsp_pkg::FUNC_VOTE)
                    begin
                        x_next     = in_data.edge_x;
                        y_next     = in_data.edge_y;
                        t_next     = in_data.edge_angle - 8'(spread_reg);
                        steps_next = {spread_reg, 1'b1};
                        state_next = S_VR0;
                    end
                    else
                    begin
                        t_next     = 8'd0;
                        col_next   = '0;
                        state_next = S_SRD;
                    end
                end
            end
            S_VR0:
                state_next = S_VR0W;
            S_VR0W:
            begin
                if (rad_done)
                begin
                    rprev_next = rad_r;
                    state_next = S_VR1;
                end
            end
            S_VR1:
                state_next = S_VR1W;
            S_VR1W:
            begin
                if (rad_done)
                begin
                    rnext_next = rad_r;
                    cur_next   = (rprev_reg < rad_r) ? rprev_reg : rad_r;
                    hi_next    = (rprev_reg < rad_r) ? rad_r : rprev_reg;
                    state_next = S_VBIN;
                end
            end
            S_VBIN, S_VWR:
            begin
                rd_a_addr = vote_addr;
                if (state_reg == S_VBIN && bin_ok)
                    state_next = S_VWR;
                else
                begin
                    // Write back the incremented bin, then advance.
                    wr_en = (state_reg == S_VWR);
                    state_next = S_VBIN;
                    if (cur_reg == hi_reg)
                    begin
                        rprev_next = rnext_reg;
                        t_next     = t_reg + 8'd1;
                        steps_next = steps_reg - 6'd1;
                        state_next = (steps_reg == 6'd1) ? S_IDLE : S_VR1;
                    end
                    else
                        cur_next = cur_reg + RADW'(1);
                end
            end
            S_SRD:
                state_next = S_SWR;
            S_SWR:
            begin
                copy_we     = (t_reg == 8'd0);
                wr_addr     = {t_reg, RW'(col_reg - (RW + 1)'(1))};
                wr_data     = box_q;
                wr_en       = (col_reg != '0);
                prev_a_next = rd_a_reg;
                prev_b_next = b_val;
                state_next  = S_SRD;
                if (col_reg == (RW + 1)'(R_BINS - 1))
                begin
                    col_next = '0;
                    t_next   = t_reg + 8'd1;
                    if (t_reg == 8'hff)
                    begin
                        col_next   = (RW + 1)'(2);
                        n_next     = 4'd0;
                        state_next = S_PRD;
                    end
                end
                else
                    col_next = col_reg + (RW + 1)'(1);
            end
            S_PRD:
            begin
                rd_a_addr = {p_row, p_col[RW-1:0]};
                n_next    = n_reg + 4'd1;
                if (n_reg != 4'd0)
                begin
                    if ((m_idx == 4'd0 && rd_a_reg == 16'h0000) ||
                        (m_idx != 4'd0 && !p_pass) || m_idx == 4'd8)
                    begin
                        if (m_idx == 4'd8 && p_pass &&
                            peak_count_reg < PCW'(MAX_PEAKS))
                        begin
                            peak_we         = 1'b1;
                            peak_count_next = peak_count_reg + PCW'(1);
                        end
                        n_next = 4'd0;
                        if (col_reg == (RW + 1)'(R_BINS - 3))
                        begin
                            col_next = (RW + 1)'(2);
                            t_next   = t_reg + 8'd1;
                            if (t_reg == 8'hff)
                            begin
                                clr_addr_next  = '0;
                                emit_pend_next = 1'b1;
                                state_next     = S_CLEAR;
                            end
                        end
                        else
                            col_next = col_reg + (RW + 1)'(1);
                    end
                    if (m_idx == 4'd0)
                        z_next = rd_a_reg;
                end
            end
            S_EMRD:
                state_next = S_EMLD;
            S_EMLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    if (peak_count_reg == '0)
                    begin
                        out_data_next = '{peak_radius: 8'd0, peak_angle: 8'd0,
                                          peak_score: 16'd0, found: 1'b0, last: 1'b1};
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        out_data_next.peak_radius = peak_rd_reg[31:24];
                        out_data_next.peak_angle  = peak_rd_reg[23:16];
                        out_data_next.peak_score  = peak_rd_reg[15:0];
                        out_data_next.found       = 1'b1;
                        out_data_next.last        = (PCW'(idx_reg + PCW'(1)) == peak_count_reg);
                        if (PCW'(idx_reg + PCW'(1)) == peak_count_reg)
                        begin
                            peak_count_next = '0;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + PCW'(1);
                            state_next = S_EMRD;
                        end
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    // Control and payload registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            spread_reg     <= 5'd2;
            thr_reg        <= 14'd0;
            x_reg          <= '0;
            y_reg          <= '0;
            t_reg          <= '0;
            steps_reg      <= '0;
            rprev_reg      <= '0;
            rnext_reg      <= '0;
            cur_reg        <= '0;
            hi_reg         <= '0;
            col_reg        <= '0;
            n_reg          <= '0;
            z_reg          <= '0;
            prev_a_reg     <= '0;
            prev_b_reg     <= '0;
            peak_count_reg <= '0;
            idx_reg        <= '0;
            emit_pend_reg  <= 1'b0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            t_reg          <= t_next;
            steps_reg      <= steps_next;
            rprev_reg      <= rprev_next;
            rnext_reg      <= rnext_next;
            cur_reg        <= cur_next;
            hi_reg         <= hi_next;
            col_reg        <= col_next;
            n_reg          <= n_next;
            z_reg          <= z_next;
            prev_a_reg     <= prev_a_next;
            prev_b_reg     <= prev_b_next;
            peak_count_reg <= peak_count_next;
            idx_reg        <= idx_next;
            emit_pend_reg  <= emit_pend_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    hlvsp_pkg::CFG_ANGLE_SPREAD:     spread_reg <= cfg_data[4:0];
                    hlvsp_pkg::CFG_ACCEPT_THRESHOLD: thr_reg    <= cfg_data;
                    default:                         thr_reg    <= thr_reg;
                endcase
            end
        end
    end

    // Accumulator: read both ports every cycle, one write.
    always_ff @(posedge clk) begin
        if (wr_en)
            acc_mem[wr_addr] <= wr_data;
        rd_a_reg <= acc_mem[rd_a_addr];
        rd_b_reg <= acc_mem[{t_reg + 8'd1, col_reg[RW-1:0]}];
    end

    // Unsmoothed row 0, saved while row 0 is smoothed.
    always_ff @(posedge clk) begin
        if (copy_we)
            copy_mem[col_reg[RW-1:0]] <= rd_a_reg;
        copy_rd_reg <= copy_mem[col_reg[RW-1:0]];
    end

    // Peak list: radius, angle, score.
    always_ff @(posedge clk) begin
        if (peak_we)
            peak_mem[peak_count_reg[PIW-1:0]] <= {8'(col_reg), t_reg, z_reg};
        peak_rd_reg <= peak_mem[idx_reg[PIW-1:0]];
    end

    `HLVSP_ASSERT_NEVER(a_peak_count_bound, peak_count_reg > PCW'(MAX_PEAKS), "peak count overflow")
    `HLVSP_ASSERT(a_no_overwrite, (out_load && out_valid_reg) |-> !out_stall, "output beat overwritten")
    `HLVSP_ASSERT(a_idle_empty, (state_reg == S_IDLE) |-> (peak_count_reg == '0), "peak list not drained")

endmodule

### hdl/hlvsp_radius.sv
module hlvsp_radius #(
    parameter int TRIG_FRAC_BITS = hlvsp_pkg::TRIG_FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [7:0]                 x,
    input  logic signed [7:0]                 y,
    input  logic [7:0]                        k,
    output logic                              done,
    output logic signed [hlvsp_pkg::RADW-1:0] radius
);

    localparam int QW = TRIG_FRAC_BITS + 2;
    localparam int PW = QW + 8;
    localparam int SW = PW + 1;

    logic signed [QW-1:0] qsin [65];
    logic [7:0]           fs;
    logic [7:0]           fc;
    logic signed [QW-1:0] sin_v;
    logic signed [QW-1:0] cos_v;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;
    logic signed [SW-1:0] sum;
    logic                 v1_reg;
    logic                 v2_reg;
    logic signed [hlvsp_pkg::RADW-1:0] radius_reg;

    for (genvar j = 0; j < 65; j++) begin : g_tab
        assign qsin[j] = QW'(hlvsp_pkg::quarter_sin(j, TRIG_FRAC_BITS));
    end

    assign fs    = hlvsp_pkg::fold_angle(k);
    assign fc    = hlvsp_pkg::fold_angle(k + 8'd64);
    assign sin_v = fs[7] ? -qsin[fs[6:0]] : qsin[fs[6:0]];
    assign cos_v = fc[7] ? -qsin[fc[6:0]] : qsin[fc[6:0]];
    assign sum   = SW'(px_reg) + SW'(py_reg);

    // Arithmetic shift gives the floor for both signs.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        px_reg     <= PW'(x) * PW'(cos_v);
        py_reg     <= PW'(y) * PW'(sin_v);
        radius_reg <= sum[SW-1:TRIG_FRAC_BITS];
    end

    assign done   = v2_reg;
    assign radius = radius_reg;

endmodule

### verif/hough_line_vote_smooth_peak_test.sv
module hough_line_vote_smooth_peak_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Limit on cycles in which no beat moves on any channel. A finish run
    // at default size walks smoothing, a peak search of up to nine reads per
    // bin and the clearing pass.
    localparam int IDLE_LIMIT = 3000000;
    localparam int SHOW_MAX   = 10;
    localparam int IN_W       = $bits(hlvsp_pkg::in_beat_t);

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    hlvsp_pkg::in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    hlvsp_pkg::out_beat_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [13:0] cfg_data;

    hough_line_vote_smooth_peak dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's state, advanced on every accepted beat.
    logic [15:0] hough_acc [256][256];
    int          sine_q14 [0:64];
    int unsigned spread_shadow;
    int unsigned thresh_shadow;

    hlvsp_pkg::in_beat_t  pending_q [$];
    hlvsp_pkg::out_beat_t peak_exp_q [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    logic in_took;
    logic beat_moved;
    int  mismatch_cnt;
    int  quiet_cycles;

    assign beat_moved = (cfg_valid && cfg_ready) || (in_valid && !in_stall)
                      || (out_valid && !out_stall);

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Quarter-wave sine table, Q1.14, rounded to nearest.
    initial begin
        for (int j = 0; j <= 64; j++)
            sine_q14[j] = int'($floor($sin(3.14159265358979323846 * j / 128.0)
                                      * 16384.0 + 0.5));
        sine_q14[0]  = 0;
        sine_q14[64] = 16384;
    end

    function automatic int sine_at(int unsigned k);
        k = k & 255;
        if (k <= 64)
            return sine_q14[k];
        else if (k < 128)
            return sine_q14[128 - k];
        else if (k <= 192)
            return -sine_q14[k - 128];
        else
            return -sine_q14[256 - k];
    endfunction

    // Floor of x*cos + y*sin; arithmetic shift floors negative sums.
    function automatic int line_radius(int x, int y, int unsigned k);
        int s;
        s = x * sine_at(k + 64) + y * sine_at(k);
        return s >>> 14;
    endfunction

    function automatic void cast_vote(int x, int y, int unsigned angle);
        int unsigned t;
        int r0;
        int r1;
        int lo;
        int hi;
        int b;
        t = (angle - spread_shadow) & 255;
        r0 = line_radius(x, y, t);
        for (int i = 0; i < 2 * spread_shadow + 1; i++) begin
            r1 = line_radius(x, y, t + 1);
            lo = (r0 < r1) ? r0 : r1;
            hi = (r0 < r1) ? r1 : r0;
            for (int r = lo; r <= hi; r++) begin
                b = r + 128;
                if (b >= 0 && b < 256 && hough_acc[t][b] != 16'hffff)
                    hough_acc[t][b] = hough_acc[t][b] + 16'd1;
            end
            r0 = r1;
            t = (t + 1) & 255;
        end
    endfunction

    function automatic int unsigned acc_at(int r, int t);
        return hough_acc[t & 255][r];
    endfunction

    // Smooth in place, search peaks, queue the expected beats, clear.
    function automatic void finish_run();
        logic [15:0] row0 [256];
        int        v;
        int unsigned z;
        bit        ok;
        int        dr [4];
        int        dt [4];
        hlvsp_pkg::out_beat_t pk;
        hlvsp_pkg::out_beat_t found_q [$];
        dr = '{1, 1, 0, -1};
        dt = '{0, 1, 1, 1};
        row0 = hough_acc[0];
        for (int t = 0; t < 256; t++) begin
            for (int r = 0; r < 255; r++) begin
                if (t < 255)
                    v = hough_acc[t][r] + hough_acc[t][r + 1]
                      + hough_acc[t + 1][r] + hough_acc[t + 1][r + 1];
                else
                    v = hough_acc[t][r] + hough_acc[t][r + 1] + row0[r] + row0[r + 1];
                v = v - 4 * int'(thresh_shadow);
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                hough_acc[t][r] = v[15:0];
            end
        end
        for (int t = 0; t < 256; t++) begin
            for (int r = 2; r < 254; r++) begin
                z = acc_at(r, t);
                ok = (z != 0);
                for (int d = 0; d < 4; d++)
                    if (ok && !(z > acc_at(r + dr[d], t + dt[d])
                                && z >= acc_at(r - dr[d], t - dt[d])))
                        ok = 1'b0;
                if (ok && found_q.size() < 64) begin
                    pk.peak_radius = r[7:0];
                    pk.peak_angle  = t[7:0];
                    pk.peak_score  = z[15:0];
                    pk.found       = 1'b1;
                    pk.last        = 1'b0;
                    found_q = {found_q, pk};
                end
            end
        end
        if (found_q.size() == 0) begin
            pk = '0;
            pk.last = 1'b1;
            found_q = {found_q, pk};
        end
        found_q[found_q.size() - 1].last = 1'b1;
        peak_exp_q = {peak_exp_q, found_q};
        for (int t = 0; t < 256; t++)
            for (int r = 0; r < 256; r++)
                hough_acc[t][r] = '0;
    endfunction

    // Driver: change inputs on the falling edge only.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_took) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_q.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: sample on the rising edge, predict and check.
    always @(posedge clk) begin
        if (rst_n) begin
            in_took <= in_valid && !in_stall;
            quiet_cycles <= beat_moved ? 0 : quiet_cycles + 1;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == hlvsp_pkg::CFG_ANGLE_SPREAD)
                    spread_shadow = cfg_data[4:0];
                else
                    thresh_shadow = cfg_data;
            end
            if (in_valid && !in_stall) begin
                if (in_data.func == hlvsp_pkg::FUNC_VOTE)
                    cast_vote(in_data.edge_x, in_data.edge_y, in_data.edge_angle);
                else
                    finish_run();
            end
            if (out_valid && !out_stall) begin
                if (peak_exp_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOW_MAX)
                        $display("unexpected peak beat %p", out_data);
                end
                else begin
                    if (out_data !== peak_exp_q[0]) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= SHOW_MAX)
                            $display("peak beat mismatch: expected %p, got %p",
                                     peak_exp_q[0], out_data);
                    end
                    void'(peak_exp_q.pop_front());
                end
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic signed [7:0] clamp8(real v);
        int n;
        n = int'(v);
        if (n > 127)
            n = 127;
        if (n < -128)
            n = -128;
        return n[7:0];
    endfunction

    // Edge point on the line with normal angle a and signed distance rho.
    function automatic hlvsp_pkg::in_beat_t line_edge(int a, int rho);
        hlvsp_pkg::in_beat_t it;
        real      c;
        real      sn;
        int       s;
        c  = $cos(3.14159265358979323846 * a / 128.0);
        sn = $sin(3.14159265358979323846 * a / 128.0);
        s  = int'($urandom_range(200)) - 100;
        it.func       = hlvsp_pkg::FUNC_VOTE;
        it.edge_x     = clamp8(rho * c - s * sn);
        it.edge_y     = clamp8(rho * sn + s * c);
        it.edge_angle = 8'(a + int'($urandom_range(4)) - 2);
        return it;
    endfunction

    function automatic hlvsp_pkg::in_beat_t edge_item(int x, int y, int a);
        hlvsp_pkg::in_beat_t it;
        it.func       = hlvsp_pkg::FUNC_VOTE;
        it.edge_x     = x[7:0];
        it.edge_y     = y[7:0];
        it.edge_angle = a[7:0];
        return it;
    endfunction

    function automatic void push_finish();
        hlvsp_pkg::in_beat_t it;
        it = IN_W'($urandom);
        it.func = hlvsp_pkg::FUNC_FINISH;
        pending_q = {pending_q, it};
    endfunction

    // Mostly points on a few random lines, some scattered noise, then finish.
    function automatic void load_batch(int n);
        int       a [3];
        int       rho [3];
        int       k;
        hlvsp_pkg::in_beat_t it;
        foreach (a[i]) begin
            a[i]   = $urandom_range(255);
            rho[i] = int'($urandom_range(180)) - 90;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 75) begin
                k = $urandom_range(2);
                pending_q = {pending_q, line_edge(a[k], rho[k])};
            end
            else begin
                it = IN_W'($urandom);
                it.func = hlvsp_pkg::FUNC_VOTE;
                pending_q = {pending_q, it};
            end
        end
        push_finish();
    endfunction

    task automatic write_reg(logic idx, logic [13:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every beat is sent and every expected peak has come back.
    task automatic drain();
        while (pending_q.size() > 0 || in_valid || peak_exp_q.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic random_phase(int spread, int thresh, int n);
        write_reg(hlvsp_pkg::CFG_ANGLE_SPREAD, 14'(spread));
        write_reg(hlvsp_pkg::CFG_ACCEPT_THRESHOLD, 14'(thresh));
        load_batch(n);
        drain();
    endtask

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = hlvsp_pkg::CFG_ANGLE_SPREAD;
        cfg_data       = '0;
        in_took        = 1'b0;
        mismatch_cnt   = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 20;
        recv_stall_pct = 80;
        spread_shadow  = 2;
        thresh_shadow  = 0;
        for (int t = 0; t < 256; t++)
            for (int r = 0; r < 256; r++)
                hough_acc[t][r] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty accumulator gives the no-peak beat, then corner
        // points and the angle wrap at both ends of the table.
        write_reg(hlvsp_pkg::CFG_ANGLE_SPREAD, 14'd0);
        write_reg(hlvsp_pkg::CFG_ACCEPT_THRESHOLD, 14'd0);
        push_finish();
        pending_q = {pending_q, edge_item(127, 127, 0)};
        pending_q = {pending_q, edge_item(-128, -128, 255)};
        pending_q = {pending_q, edge_item(127, -128, 64)};
        pending_q = {pending_q, edge_item(-128, 127, 128)};
        pending_q = {pending_q, edge_item(0, 0, 192)};
        pending_q = {pending_q, edge_item(5, -3, 1)};
        push_finish();
        drain();
        write_reg(hlvsp_pkg::CFG_ANGLE_SPREAD, 14'd31);
        pending_q = {pending_q, edge_item(127, 0, 0)};
        pending_q = {pending_q, edge_item(0, -128, 200)};
        pending_q = {pending_q, edge_item(-1, -1, 127)};
        pending_q = {pending_q, edge_item(-128, 127, 255)};
        push_finish();
        drain();

        // Sender mostly busy, receiver stalls hard.
        send_idle_pct  = 20;
        recv_stall_pct = 80;
        random_phase(31, 0, 40);
        random_phase(5, 1, 40);

        // Sender sparse, receiver mostly ready; full threshold wipes all peaks.
        send_idle_pct  = 80;
        recv_stall_pct = 20;
        random_phase(0, 16383, 30);
        random_phase(17, 3, 40);

        // No idling at all.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(2, 0, 45);
        random_phase(10, 2, 45);

        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/hlvsp_pkg.sv
hdl/hlvsp_radius.sv
hdl/hough_line_vote_smooth_peak.sv
verif/hough_line_vote_smooth_peak_test.sv
